// ----- src/pls_pkg.sv -----
// package: shared constants, phase codes, prefix flags and helper for path_root_length_parser
package pls_pkg;

	localparam int MAX_LEN_DEF = 4096;
	localparam int ROOT_W      = 13;
	localparam int OUT_MAX     = 8191;
	localparam int PREFIX_N    = 8;
	localparam int PHASE_W     = 3;

	localparam logic [PHASE_W-1:0] PH_START  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SERVER = 3'd1;
	localparam logic [PHASE_W-1:0] PH_SHARE  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_DONE   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_WAIT   = 3'd4;
	localparam logic [PHASE_W-1:0] PH_NONE   = 3'd5;

	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_C     = 8'h43;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic lead_qmark;
		logic lead_dot;
		logic sep0;
		logic sep1;
		logic drive;
		logic qmark_drive;
		logic unc;
	} pfx_flags_t;

	function automatic logic is_sep(input logic [7:0] c);
		return (c == CH_BSL) || (c == CH_SLASH);
	endfunction

endpackage

// ----- src/pls_scan.sv -----
// scan state: position counter, prefix bytes, server/share phase and indices
module pls_scan import pls_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF,
	parameter int PW = $clog2(MAX_LEN + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic [7:0]    path_byte,
	input  logic          last_byte,
	output logic [PW-1:0] len,
	output logic [PW-1:0] server_end,
	output logic [PW-1:0] share_end,
	output pfx_flags_t    flags
);

	localparam logic [PW-1:0] MAX_P = PW'(MAX_LEN);

	logic [PW-1:0]      pos_q;
	logic [PHASE_W-1:0] phase_q;
	logic [PW-1:0]      srv_q;
	logic [PW-1:0]      shr_q;
	logic [7:0]         prefix_q [PREFIX_N];

	logic [7:0]         prefix_n [PREFIX_N];
	logic [PHASE_W-1:0] phase_n;
	logic [PW-1:0]      srv_n;
	logic [PW-1:0]      shr_n;
	logic               lead_q_n;
	logic               lead_d_n;
	logic               unc_n;

	always_comb begin
		prefix_n = prefix_q;
		if (pos_q < PW'(PREFIX_N)) begin
			prefix_n[pos_q[2:0]] = path_byte;
		end

		lead_q_n = (prefix_n[0] == CH_BSL) && (prefix_n[1] == CH_BSL) &&
			(prefix_n[2] == CH_QMARK) && (prefix_n[3] == CH_BSL);
		lead_d_n = (prefix_n[0] == CH_BSL) && (prefix_n[1] == CH_BSL) &&
			(prefix_n[2] == CH_DOT) && (prefix_n[3] == CH_BSL);
		unc_n = (prefix_n[4] == CH_U) && (prefix_n[5] == CH_N) &&
			(prefix_n[6] == CH_C) && (prefix_n[7] == CH_BSL);

		phase_n = phase_q;
		srv_n   = srv_q;
		shr_n   = shr_q;
		if (pos_q == PW'(2)) begin
			phase_n = (is_sep(prefix_n[0]) && is_sep(prefix_n[1])) ? PH_SERVER : PH_NONE;
			srv_n   = '0;
			shr_n   = '0;
		end else if (pos_q == PW'(4) && phase_q != PH_NONE) begin
			if (lead_q_n) begin
				phase_n = PH_WAIT;
				srv_n   = '0;
				shr_n   = '0;
			end else if (lead_d_n) begin
				phase_n = PH_SERVER;
				srv_n   = '0;
				shr_n   = '0;
			end
		end else if (pos_q == PW'(8) && phase_q == PH_WAIT) begin
			phase_n = unc_n ? PH_SERVER : PH_NONE;
			srv_n   = '0;
			shr_n   = '0;
		end

		if (is_sep(path_byte)) begin
			if (phase_n == PH_SERVER) begin
				srv_n   = pos_q;
				phase_n = PH_SHARE;
			end else if (phase_n == PH_SHARE) begin
				shr_n   = pos_q;
				phase_n = PH_DONE;
			end
		end

		len = (pos_q < MAX_P) ? pos_q + PW'(1) : pos_q;
		server_end = srv_n;
		share_end  = shr_n;

		flags.phase       = phase_n;
		flags.lead_qmark  = lead_q_n;
		flags.lead_dot    = lead_d_n;
		flags.sep0        = is_sep(prefix_n[0]);
		flags.sep1        = is_sep(prefix_n[1]);
		flags.drive       = (prefix_n[1] == CH_COLON) && is_sep(prefix_n[2]);
		flags.qmark_drive = (prefix_n[5] == CH_COLON) && is_sep(prefix_n[6]);
		flags.unc         = unc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PH_START;
			srv_q   <= '0;
			shr_q   <= '0;
		end else if (advance) begin
			if (last_byte) begin
				pos_q   <= '0;
				phase_q <= PH_START;
				srv_q   <= '0;
				shr_q   <= '0;
			end else begin
				pos_q   <= len;
				phase_q <= phase_n;
				srv_q   <= srv_n;
				shr_q   <= shr_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prefix_q <= prefix_n;
		end
	end

endmodule

// ----- src/pls_root.sv -----
// root decision: picks the root length from the prefix flags and scan indices
module pls_root import pls_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF,
	parameter int PW = $clog2(MAX_LEN + 1)
) (
	input  logic [PW-1:0]     len,
	input  logic [PW-1:0]     server_end,
	input  logic [PW-1:0]     share_end,
	input  pfx_flags_t        flags,
	output logic [ROOT_W-1:0] root_length
);

	localparam int RW = (PW > ROOT_W) ? PW : ROOT_W;

	logic          split;
	logic          srv_in;
	logic          shr_in;
	logic [PW-1:0] tail;
	logic [PW-1:0] ss8;
	logic [PW-1:0] ss2;
	logic [PW-1:0] r;
	logic [RW-1:0] r_ext;

	always_comb begin
		split  = (flags.phase == PH_SHARE) || (flags.phase == PH_DONE);
		srv_in = server_end < len;
		shr_in = share_end < len;
		tail   = (flags.phase == PH_DONE && shr_in) ? share_end : len;
		ss8    = (split && server_end > PW'(8) && srv_in) ? tail : '0;
		ss2    = (split && server_end > PW'(2) && srv_in) ? tail : '0;

		if (len >= PW'(4) && flags.lead_qmark) begin
			if (len >= PW'(7) && flags.qmark_drive) begin
				r = PW'(7);
			end else if (len >= PW'(8) && flags.unc && ss8 != '0) begin
				r = ss8;
			end else begin
				r = PW'(4);
			end
		end else if (len >= PW'(4) && flags.lead_dot) begin
			r = (split && srv_in) ? server_end : len;
		end else if (len >= PW'(4) && flags.sep0 && flags.sep1) begin
			r = ss2;
		end else if (len >= PW'(3) && flags.drive) begin
			r = PW'(3);
		end else if (len >= PW'(1) && flags.sep0) begin
			r = (len >= PW'(2) && flags.sep1) ? PW'(0) : PW'(1);
		end else begin
			r = '0;
		end

		r_ext = RW'(r);
		root_length = (r_ext > RW'(OUT_MAX)) ? ROOT_W'(OUT_MAX) : r_ext[ROOT_W-1:0];
	end

endmodule

// ----- src/path_root_length_parser_top.sv -----
// top level: input register, scan and root logic, output register for path_root_length_parser
//
//  channel | handshake          | word
//  --------+--------------------+-------------------------------
//  in      | in_valid/in_ready  | path_byte[7:0], last_byte
//  out     | out_valid/out_ready| root_length[12:0]
//
// one word per cycle sustained; a word waits in the input register
// and the state registers update as it leaves, so root_length is written to the output
// register as the final word leaves the input register
// only a final word stalls, while the output register still holds an untaken result
// reset clears the position counter, scan phase, indices and valid flags; no clearing pass
module path_root_length_parser_top import pls_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        path_byte,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ROOT_W-1:0] root_length
);

	localparam int PW = $clog2(MAX_LEN + 1);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              out_valid_q;
	logic [ROOT_W-1:0] root_q;

	logic              advance;
	logic [PW-1:0]     len;
	logic [PW-1:0]     server_end;
	logic [PW-1:0]     share_end;
	pfx_flags_t        flags;
	logic [ROOT_W-1:0] root_c;

	assign advance  = valid_s1 && !(last_s1 && out_valid_q && !out_ready);
	assign in_ready = !valid_s1 || advance;

	pls_scan #(
		.MAX_LEN (MAX_LEN),
		.PW      (PW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.path_byte  (byte_s1),
		.last_byte  (last_s1),
		.len        (len),
		.server_end (server_end),
		.share_end  (share_end),
		.flags      (flags)
	);

	pls_root #(
		.MAX_LEN (MAX_LEN),
		.PW      (PW)
	) u_root (
		.len         (len),
		.server_end  (server_end),
		.share_end   (share_end),
		.flags       (flags),
		.root_length (root_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= path_byte;
			last_s1 <= last_byte;
		end
		if (advance && last_s1) begin
			root_q <= root_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign root_length = root_q;

endmodule

// ----- verif/tb_top.sv -----
// testbench for path_root_length_parser_top: path streams, root length prediction and checking
module tb_top import pls_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RAND_WORDS  = 640;

	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         drain;
	} path_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        path_byte = '0;
	logic              last_byte = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [ROOT_W-1:0] root_length;

	path_word_t        word_q[$];
	logic [7:0]        path_q[$];
	logic [ROOT_W-1:0] root_exp_q[$];

	int cycles;
	int errors;
	int paths_sent;
	int roots_checked;
	int tx_wait;
	int tx_calm;
	int rx_wait;
	int rx_calm;

	// predictor state
	int         pos_cnt;
	logic [7:0] lead_bytes[PREFIX_N];
	logic [2:0] scan_ph;
	int         srv_idx;
	int         shr_idx;

	path_root_length_parser_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.path_byte  (path_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.root_length(root_length)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit sep_char(input logic [7:0] c);
		return (c == CH_BSL) || (c == CH_SLASH);
	endfunction

	function automatic bit lead_match(input logic [7:0] mid);
		return lead_bytes[0] == CH_BSL && lead_bytes[1] == CH_BSL &&
			lead_bytes[2] == mid && lead_bytes[3] == CH_BSL;
	endfunction

	function automatic bit unc_match();
		return lead_bytes[4] == CH_U && lead_bytes[5] == CH_N &&
			lead_bytes[6] == CH_C && lead_bytes[7] == CH_BSL;
	endfunction

	task automatic rescan(input logic [2:0] ph);
		scan_ph = ph;
		srv_idx = 0;
		shr_idx = 0;
	endtask

	function automatic int share_end_at(input int start, input int len);
		if (!((scan_ph == PH_SHARE || scan_ph == PH_DONE) && srv_idx > start && srv_idx < len))
			return 0;
		if (scan_ph == PH_DONE && shr_idx < len)
			return shr_idx;
		return len;
	endfunction

	function automatic int root_len(input int len);
		int r;
		if (len >= 4 && lead_match(CH_QMARK)) begin
			if (len >= 7 && lead_bytes[5] == CH_COLON && sep_char(lead_bytes[6]))
				return 7;
			if (len >= 8 && unc_match()) begin
				r = share_end_at(8, len);
				if (r != 0)
					return r;
			end
			return 4;
		end
		if (len >= 4 && lead_match(CH_DOT)) begin
			if ((scan_ph == PH_SHARE || scan_ph == PH_DONE) && srv_idx < len)
				return srv_idx;
			return len;
		end
		if (len >= 4 && sep_char(lead_bytes[0]) && sep_char(lead_bytes[1]))
			return share_end_at(2, len);
		if (len >= 3 && lead_bytes[1] == CH_COLON && sep_char(lead_bytes[2]))
			return 3;
		if (len >= 1 && sep_char(lead_bytes[0])) begin
			if (len >= 2)
				return sep_char(lead_bytes[1]) ? 0 : 1;
			return 1;
		end
		return 0;
	endfunction

	task automatic predict_word(input logic [7:0] b, input logic l);
		int p;
		int r;
		p = pos_cnt;
		if (p < PREFIX_N)
			lead_bytes[p] = b;
		if (p == 2) begin
			rescan((sep_char(lead_bytes[0]) && sep_char(lead_bytes[1])) ? PH_SERVER : PH_NONE);
		end else if (p == 4 && scan_ph != PH_NONE) begin
			if (lead_match(CH_QMARK))
				rescan(PH_WAIT);
			else if (lead_match(CH_DOT))
				rescan(PH_SERVER);
		end else if (p == 8 && scan_ph == PH_WAIT) begin
			rescan(unc_match() ? PH_SERVER : PH_NONE);
		end
		if (sep_char(b)) begin
			if (scan_ph == PH_SERVER) begin
				srv_idx = p;
				scan_ph = PH_SHARE;
			end else if (scan_ph == PH_SHARE) begin
				shr_idx = p;
				scan_ph = PH_DONE;
			end
		end
		if (pos_cnt < MAX_LEN_DEF)
			pos_cnt++;
		if (l) begin
			r = root_len(pos_cnt);
			if (r > OUT_MAX)
				r = OUT_MAX;
			root_exp_q.push_back(r[ROOT_W-1:0]);
			pos_cnt = 0;
			rescan(PH_START);
		end
	endtask

	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 30) == 0)
			calm = $urandom_range(10, 40);
		return $urandom_range(0, 17);
	endfunction

	function automatic logic [7:0] rand_char();
		case ($urandom_range(0, 19))
			0: return CH_BSL;
			1: return CH_SLASH;
			2: return CH_DOT;
			3: return CH_COLON;
			4: return CH_QMARK;
			5: return 8'h20 + 8'($urandom_range(0, 94));
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [7:0] rand_sep();
		return $urandom_range(0, 1) ? CH_BSL : CH_SLASH;
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			path_q.push_back(s[i]);
	endtask

	task automatic add_seg(input int n);
		for (int i = 0; i < n; i++)
			path_q.push_back(rand_char());
	endtask

	task automatic commit_path(input bit drain, output int n);
		path_word_t w;
		n = path_q.size();
		for (int i = 0; i < n; i++) begin
			w.data = path_q[i];
			w.last = (i == n - 1);
			w.drain = drain && (i == 0);
			word_q.push_back(w);
		end
		path_q.delete();
	endtask

	task automatic directed_path(input string s);
		int n;
		add_text(s);
		commit_path(1'b0, n);
	endtask

	task automatic random_path(input bit drain, output int n);
		case ($urandom_range(0, 9))
			0: begin
				path_q.push_back(8'h41 + 8'($urandom_range(0, 25)));
				path_q.push_back(CH_COLON);
				path_q.push_back(rand_sep());
			end
			1: begin
				add_text("\\\\?\\");
				path_q.push_back(8'h41 + 8'($urandom_range(0, 25)));
				path_q.push_back(CH_COLON);
				path_q.push_back(rand_sep());
			end
			2, 3: begin
				add_text($urandom_range(0, 5) == 0 ? "\\\\?\\Unc\\" : "\\\\?\\UNC\\");
				add_seg($urandom_range(0, 5));
				path_q.push_back(rand_sep());
				add_seg($urandom_range(0, 5));
				path_q.push_back(rand_sep());
			end
			4: begin
				add_text("\\\\.\\");
				add_seg($urandom_range(0, 6));
				path_q.push_back(rand_sep());
			end
			5, 6: begin
				path_q.push_back(rand_sep());
				path_q.push_back(rand_sep());
				add_seg($urandom_range(0, 5));
				path_q.push_back(rand_sep());
				add_seg($urandom_range(0, 5));
				path_q.push_back(rand_sep());
			end
			7: path_q.push_back(rand_sep());
			8: begin
				for (int i = $urandom_range(1, 12); i > 0; i--)
					path_q.push_back(8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
		add_seg($urandom_range(0, 6));
		if ($urandom_range(0, 3) == 0 && path_q.size() > 1) begin
			n = $urandom_range(1, path_q.size() - 1);
			while (path_q.size() > n)
				void'(path_q.pop_back());
		end
		if (path_q.size() == 0)
			path_q.push_back(rand_char());
		commit_path(drain, n);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		path_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			path_byte <= '0;
			last_byte <= 1'b0;
			tx_wait = 0;
			tx_calm = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_word(path_byte, last_byte);
				if (last_byte)
					paths_sent++;
			end
			if (!in_valid || in_ready) begin
				if (tx_wait != 0) begin
					tx_wait--;
					in_valid <= 1'b0;
				end else if (word_q.size() != 0 &&
						!(word_q[0].drain && (root_exp_q.size() != 0 || in_valid))) begin
					w = word_q.pop_front();
					in_valid <= 1'b1;
					path_byte <= w.data;
					last_byte <= w.last;
					tx_wait = draw_gap(tx_calm);
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		logic [ROOT_W-1:0] want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait = 0;
			rx_calm = 0;
		end else if (out_valid && out_ready) begin
			if (root_exp_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected root_length %0d", $time, root_length);
			end else begin
				want = root_exp_q.pop_front();
				if (root_length !== want) begin
					errors++;
					$display("%0t: root_length expected %0d actual %0d", $time, want,
						root_length);
				end
			end
			roots_checked++;
			rx_wait = draw_gap(rx_calm);
			out_ready <= (rx_wait == 0);
		end else if (rx_wait != 0) begin
			rx_wait--;
			out_ready <= (rx_wait == 0);
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d roots pending", cycles, root_exp_q.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int n;
		int rand_words;
		pos_cnt = 0;
		rescan(PH_START);

		directed_path("\\\\?\\C:\\dir");
		directed_path("\\\\?\\C:");
		directed_path("\\\\?\\");
		directed_path("\\\\?\\UNC\\srv\\shr\\f");
		directed_path("\\\\?\\UNC\\");
		directed_path("\\\\?\\UNC\\\\x");
		directed_path("\\\\?\\UNC\\srv");
		directed_path("\\\\?\\UNC\\srv\\shr");
		directed_path("\\\\?\\unc\\s\\t");
		directed_path("\\\\.\\COM1\\x");
		directed_path("\\\\.\\dev");
		directed_path("\\\\.\\");
		directed_path("\\\\srv\\shr\\f");
		directed_path("//srv/shr");
		directed_path("\\\\\\x");
		directed_path("\\\\srv");
		directed_path("C:\\x");
		directed_path("C:/");
		directed_path("C:");
		directed_path("\\x");
		directed_path("\\");
		directed_path("/\\");
		directed_path("\\\\x");
		directed_path("a");
		path_q.push_back(8'h00);
		commit_path(1'b0, n);
		path_q.push_back(8'hFF);
		commit_path(1'b0, n);

		rand_words = 0;
		random_path(1'b1, n);
		rand_words += n;
		while (rand_words < RAND_WORDS) begin
			random_path($urandom_range(0, 49) == 0, n);
			rand_words += n;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		wait (word_q.size() == 0 && !in_valid);
		wait (root_exp_q.size() == 0);
		repeat (10) @(posedge clk);

		$display("%0d paths streamed, %0d root lengths checked, %0d mismatches", paths_sent,
			roots_checked, errors);
		$display("covered drive, verbatim, UNC, device and server/share paths");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
